/* hdl/esm_pkg.sv */
// esm_pkg: operation and status codes for the entity slot map
// no dependencies; imported by the slot map top level
`default_nettype none

package esm_pkg;

    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER    = 3'd0,
        OP_DELETE      = 3'd1,
        OP_HAS         = 3'd2,
        OP_SLOT_OF_KEY = 3'd3,
        OP_KEY_OF_SLOT = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

endpackage

`default_nettype wire

/* hdl/entity_slot_map_with_free_fifo.sv */
// entity_slot_map_with_free_fifo: key to slot table with a fifo of freed slots
// a request is resolved by a sequential scan of the entry ram, one entry per cycle;
// the next request is accepted only after the result of the last one is registered
// reset: a clearing pass zeroes every entry of the entry ram, ready stays low
// depends on esm_pkg and esm_ram
`default_nettype none

module entity_slot_map_with_free_fifo
    import esm_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int SLOT_BITS = 16,
    parameter int KEY_BITS  = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [OP_W-1:0]      i_operation,
    input  wire logic [KEY_BITS-1:0]  i_entity_key,
    input  wire logic [SLOT_BITS-1:0] i_current_size,
    input  wire logic [SLOT_BITS-1:0] i_slot_query,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [SLOT_BITS-1:0]      o_slot,
    output logic [KEY_BITS-1:0]       o_entity_out,
    output logic                      o_found,
    output logic [1:0]                o_status
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;
    localparam int ENT_W = 1 + KEY_BITS + SLOT_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTRIES);
    localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(ENTRIES);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_rd_on;
    logic                 r_cmp_on;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic                 r_cmp_last;

    logic [OP_W-1:0]      r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [SLOT_BITS-1:0] r_size;
    logic [SLOT_BITS-1:0] r_query;

    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic [SLOT_BITS-1:0] r_hit_slot;
    logic                 r_emp;
    logic [IDX_W-1:0]     r_emp_idx;
    logic                 r_rev;
    logic [KEY_BITS-1:0]  r_rev_key;

    logic [IDX_W-1:0]     r_free_head;
    logic [CNT_W-1:0]     r_free_count;

    logic                 r_out_valid;
    logic [SLOT_BITS-1:0] r_slot;
    logic [KEY_BITS-1:0]  r_ent_out;
    logic                 r_found;
    logic [1:0]           r_status;

    logic                 ent_we;
    logic [IDX_W-1:0]     ent_waddr;
    logic [ENT_W-1:0]     ent_wdata;
    logic                 ent_re;
    logic [ENT_W-1:0]     ent_rdata;
    logic                 free_we;
    logic [IDX_W-1:0]     free_waddr;
    logic                 free_re;
    logic [SLOT_BITS-1:0] free_rdata;

    logic                 in_acc;
    logic                 out_free;
    logic                 res_go;
    logic                 rd_valid;
    logic [KEY_BITS-1:0]  rd_key;
    logic [SLOT_BITS-1:0] rd_slot;
    logic                 key_eq;
    logic                 key_lt;

    logic [SLOT_BITS-1:0] take_slot;
    logic [CNT_W:0]       tail_sum;
    logic [IDX_W-1:0]     tail_idx;
    logic [SLOT_BITS-1:0] res_slot;
    logic [KEY_BITS-1:0]  res_ent;
    logic                 res_found;
    t_status              res_status;
    logic                 res_wr;
    logic [IDX_W-1:0]     res_wr_idx;
    logic [ENT_W-1:0]     res_wr_data;
    logic                 res_pop;
    logic                 res_push;
    logic [IDX_W-1:0]     n_free_head;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign res_go   = (r_state == S_RESOLVE) && out_free;

    assign rd_valid = ent_rdata[ENT_W-1];
    assign rd_key   = ent_rdata[KEY_BITS+SLOT_BITS-1:SLOT_BITS];
    assign rd_slot  = ent_rdata[SLOT_BITS-1:0];
    assign key_eq   = rd_key == r_key;
    assign key_lt   = rd_key < r_rev_key;

    assign take_slot   = (r_free_count == '0) ? r_size : free_rdata;
    assign tail_sum    = (CNT_W + 1)'(r_free_head) + (CNT_W + 1)'(r_free_count);
    assign tail_idx    = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                                 : IDX_W'(tail_sum);
    assign n_free_head = (r_free_head == LAST_IDX) ? '0 : r_free_head + 1'b1;

    // result and table update for the current request
    always_comb begin
        res_slot    = '0;
        res_ent     = '0;
        res_found   = 1'b0;
        res_status  = ST_OK;
        res_wr      = 1'b0;
        res_wr_idx  = r_hit_idx;
        res_wr_data = {1'b1, r_key, take_slot};
        res_pop     = 1'b0;
        res_push    = 1'b0;
        unique case (r_op)
            OP_REGISTER: begin
                if (r_hit) begin
                    res_wr    = 1'b1;
                    res_pop   = r_free_count != '0;
                    res_slot  = take_slot;
                    res_found = 1'b1;
                end else if (r_emp) begin
                    res_wr     = 1'b1;
                    res_wr_idx = r_emp_idx;
                    res_pop    = r_free_count != '0;
                    res_slot   = take_slot;
                end else begin
                    res_status = ST_FULL;
                end
            end
            OP_DELETE: begin
                if (r_hit) begin
                    res_wr      = 1'b1;
                    res_wr_data = {1'b0, r_key, r_hit_slot};
                    res_push    = r_free_count != FULL_CNT;
                    res_slot    = r_hit_slot;
                    res_found   = 1'b1;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_HAS, OP_SLOT_OF_KEY: begin
                if (r_hit) begin
                    res_slot  = r_hit_slot;
                    res_found = 1'b1;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_KEY_OF_SLOT: begin
                if (r_rev) begin
                    res_slot  = r_query;
                    res_ent   = r_rev_key;
                    res_found = 1'b1;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // ram port control
    always_comb begin
        ent_we     = 1'b0;
        ent_waddr  = r_clr_idx;
        ent_wdata  = '0;
        if (r_state == S_CLEAR) begin
            ent_we = 1'b1;
        end else if (res_go && res_wr) begin
            ent_we    = 1'b1;
            ent_waddr = res_wr_idx;
            ent_wdata = res_wr_data;
        end
        ent_re     = (r_state == S_SCAN) && r_rd_on;
        free_re    = in_acc;
        free_we    = res_go && res_push;
        free_waddr = tail_idx;
    end

    esm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (r_rd_idx),
        .o_rdata (ent_rdata)
    );

    esm_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (ENTRIES)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (r_hit_slot),
        .i_re    (free_re),
        .i_raddr (r_free_head),
        .o_rdata (free_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_idx    <= '0;
            r_rd_on      <= 1'b0;
            r_cmp_on     <= 1'b0;
            r_free_head  <= '0;
            r_free_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_idx <= r_clr_idx + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= i_operation;
                        r_key    <= i_entity_key;
                        r_size   <= i_current_size;
                        r_query  <= i_slot_query;
                        r_hit    <= 1'b0;
                        r_emp    <= 1'b0;
                        r_rev    <= 1'b0;
                        r_rd_idx <= '0;
                        r_rd_on  <= 1'b1;
                        r_cmp_on <= 1'b0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cmp_on <= r_rd_on;
                    if (r_rd_on) begin
                        r_cmp_idx  <= r_rd_idx;
                        r_cmp_last <= r_rd_idx == LAST_IDX;
                        if (r_rd_idx == LAST_IDX) begin
                            r_rd_on <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                    end
                    if (r_cmp_on) begin
                        if (rd_valid && key_eq && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_cmp_idx;
                            r_hit_slot <= rd_slot;
                        end
                        if (!rd_valid && !r_emp) begin
                            r_emp     <= 1'b1;
                            r_emp_idx <= r_cmp_idx;
                        end
                        if (rd_valid && rd_slot == r_query && (!r_rev || key_lt)) begin
                            r_rev     <= 1'b1;
                            r_rev_key <= rd_key;
                        end
                        if (r_cmp_last) begin
                            r_state <= S_RESOLVE;
                        end
                    end
                end
                S_RESOLVE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_slot      <= res_slot;
                        r_ent_out   <= res_ent;
                        r_found     <= res_found;
                        r_status    <= res_status;
                        if (res_pop) begin
                            r_free_head  <= n_free_head;
                            r_free_count <= r_free_count - 1'b1;
                        end else if (res_push) begin
                            r_free_count <= r_free_count + 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = r_state == S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_slot;
    assign o_entity_out = r_ent_out;
    assign o_found      = r_found;
    assign o_status     = r_status;

endmodule

`default_nettype wire

/* hdl/esm_ram.sv */
// esm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module esm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* test/tb_entity_slot_map_with_free_fifo.sv */
`timescale 1ns / 1ps
// tb_entity_slot_map_with_free_fifo: self-checking bench for the key to slot map with free fifo
// a scoreboard class predicts every reply from its own copy of the table and the freed-slot fifo
// depends on esm_pkg and entity_slot_map_with_free_fifo

module tb_entity_slot_map_with_free_fifo;
    import esm_pkg::*;

    localparam int ENTRIES         = 64;
    localparam int SLOT_BITS       = 16;
    localparam int KEY_BITS        = 32;
    localparam int RANDOM_REQUESTS = 1700;
    localparam int KEY_POOL        = 96;
    localparam int SEGMENT         = 150;
    localparam int QUIET_FIRST     = 500;
    localparam int QUIET_LAST      = 900;
    localparam int HOLD_AT         = 200;
    localparam int HOLD_CYCLES     = 600;
    localparam int DRAIN_CYCLES    = ENTRIES + 8;
    localparam int TIMEOUT_NS      = 10_000_000;
    localparam int MAX_PRINTED     = 100;

    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [KEY_BITS-1:0]  entity;
        logic                 found;
        logic [1:0]           status;
    } reply_t;

    class slot_map_scoreboard;
        logic                 live [ENTRIES];
        logic [KEY_BITS-1:0]  keys [ENTRIES];
        logic [SLOT_BITS-1:0] slots [ENTRIES];
        logic [SLOT_BITS-1:0] freed_slots [$];
        reply_t               expected_replies [$];
        int                   errors = 0;
        int                   checked = 0;
        int                   op_count [8];
        int                   full_count = 0;
        int                   reuse_count = 0;

        function new();
            foreach (live[i]) live[i] = 1'b0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [KEY_BITS-1:0] key,
                                   logic [SLOT_BITS-1:0] size, logic [SLOT_BITS-1:0] query);
            reply_t r;
            int     hit;
            int     i;
            r   = '0;
            hit = -1;
            for (i = 0; i < ENTRIES; i++)
                if (hit < 0 && live[i] && keys[i] == key) hit = i;
            op_count[op]++;
            case (op)
                OP_REGISTER: begin
                    if (hit < 0)
                        for (i = 0; i < ENTRIES; i++)
                            if (hit < 0 && !live[i]) hit = i;
                    if (hit < 0) begin
                        r.status = ST_FULL;
                        full_count++;
                    end else begin
                        r.found   = live[hit];
                        live[hit] = 1'b1;
                        keys[hit] = key;
                        if (freed_slots.size() == 0) begin
                            slots[hit] = size;
                        end else begin
                            slots[hit] = freed_slots.pop_front();
                            reuse_count++;
                        end
                        r.slot = slots[hit];
                    end
                end
                OP_DELETE: begin
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.slot    = slots[hit];
                        r.found   = 1'b1;
                        live[hit] = 1'b0;
                        if (freed_slots.size() < ENTRIES)
                            freed_slots.insert(freed_slots.size(), slots[hit]);
                    end
                end
                OP_HAS, OP_SLOT_OF_KEY: begin
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.slot  = slots[hit];
                        r.found = 1'b1;
                    end
                end
                OP_KEY_OF_SLOT: begin
                    for (i = 0; i < ENTRIES; i++)
                        if (live[i] && slots[i] == query && (!r.found || keys[i] < r.entity)) begin
                            r.entity = keys[i];
                            r.found  = 1'b1;
                        end
                    if (r.found) r.slot = query;
                    else r.status = ST_NOT_FOUND;
                end
                default: ;
            endcase
            expected_replies.insert(expected_replies.size(), r);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] mismatch on reply %0d: %s", $time, checked, msg);
            errors++;
        endtask

        task check_reply(reply_t got);
            reply_t want;
            if (expected_replies.size() == 0) begin
                report($sformatf("reply with no request outstanding, slot %0h", got.slot));
            end else begin
                want = expected_replies.pop_front();
                if (got.slot !== want.slot)
                    report($sformatf("slot got %0h want %0h", got.slot, want.slot));
                if (got.entity !== want.entity)
                    report($sformatf("entity_out got %0h want %0h", got.entity, want.entity));
                if (got.found !== want.found)
                    report($sformatf("found got %0b want %0b", got.found, want.found));
                if (got.status !== want.status)
                    report($sformatf("status got %0d want %0d", got.status, want.status));
            end
            checked++;
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [OP_W-1:0]      i_operation = '0;
    logic [KEY_BITS-1:0]  i_entity_key = '0;
    logic [SLOT_BITS-1:0] i_current_size = '0;
    logic [SLOT_BITS-1:0] i_slot_query = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [SLOT_BITS-1:0] o_slot;
    logic [KEY_BITS-1:0]  o_entity_out;
    logic                 o_found;
    logic [1:0]           o_status;

    slot_map_scoreboard   board;
    logic [KEY_BITS-1:0]  key_pool [KEY_POOL];
    bit                   sender_gaps = 1'b1;
    int                   replies = 0;
    int                   hold_left = 0;
    bit                   held = 1'b0;
    reply_t               got;

    entity_slot_map_with_free_fifo #(
        .ENTRIES   (ENTRIES),
        .SLOT_BITS (SLOT_BITS),
        .KEY_BITS  (KEY_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_entity_key   (i_entity_key),
        .i_current_size (i_current_size),
        .i_slot_query   (i_slot_query),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_slot         (o_slot),
        .o_entity_out   (o_entity_out),
        .o_found        (o_found),
        .o_status       (o_status)
    );

    always #4 i_clk = ~i_clk;

    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_BITS-1:0] key,
                                input logic [SLOT_BITS-1:0] size,
                                input logic [SLOT_BITS-1:0] query);
        int gap;
        gap = (sender_gaps && $urandom_range(99) < 24) ? $urandom_range(2 * ENTRIES, 1) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_entity_key   <= key;
        i_current_size <= size;
        i_slot_query   <= query;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(op, key, size, query);
    endtask

    // reply side: random stalls, one long hold-off, a quiet stretch with no stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_out_ready && o_out_valid) begin
                got = '{o_slot, o_entity_out, o_found, o_status};
                board.check_reply(got);
                replies++;
            end
            if (!held && replies == HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= (replies >= QUIET_FIRST && replies < QUIET_LAST) ||
                               ($urandom_range(99) >= 24);
            end
        end
    end

    initial begin
        int                   n;
        int                   c;
        int                   pick;
        int                   reg_pct;
        int                   del_pct;
        logic [OP_W-1:0]      op;
        logic [KEY_BITS-1:0]  key;
        logic [SLOT_BITS-1:0] size;
        logic [SLOT_BITS-1:0] query;

        board = new();
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = '0;
        key_pool[1] = '1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lookups on an empty table
        send_request(OP_HAS, '0, '0, '0);
        send_request(OP_DELETE, '1, '1, '1);
        send_request(OP_KEY_OF_SLOT, '0, '0, '0);
        send_request(OP_SLOT_OF_KEY, '0, '0, '1);
        // new keys, then overwrite of a present key with an empty fifo
        send_request(OP_REGISTER, '0, '0, '0);
        send_request(OP_REGISTER, '1, '1, '0);
        send_request(OP_REGISTER, 32'h7, 16'h5, '0);
        send_request(OP_REGISTER, '0, 16'h5, '1);
        // two keys on one slot, smallest wins
        send_request(OP_KEY_OF_SLOT, 32'h7, '0, 16'h5);
        send_request(OP_KEY_OF_SLOT, '0, '0, '1);
        send_request(OP_SLOT_OF_KEY, '1, '0, '0);
        send_request(OP_HAS, 32'h7, '0, '0);
        // free both, then reuse from the fifo, including for a present key
        send_request(OP_DELETE, '0, '0, '0);
        send_request(OP_DELETE, 32'h7, '0, '0);
        send_request(OP_REGISTER, 32'h1234_5678, 16'd100, '0);
        send_request(OP_REGISTER, '1, 16'h3, '0);
        send_request(OP_KEY_OF_SLOT, '0, '0, '1);
        send_request(OP_KEY_OF_SLOT, '0, '0, 16'h5);
        for (c = OP_SPARE_LO; c <= OP_SPARE_HI; c++)
            send_request(OP_W'(c), $urandom, SLOT_BITS'($urandom), SLOT_BITS'($urandom));
        send_request(OP_DELETE, '1, '0, '0);
        send_request(OP_HAS, '1, '0, '0);

        // alternate fill-heavy and drain-heavy segments so the table fills up and empties
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            sender_gaps = !(n >= QUIET_FIRST && n < QUIET_LAST);
            reg_pct = ((n / SEGMENT) % 2 == 0) ? 60 : 20;
            del_pct = ((n / SEGMENT) % 2 == 0) ? 15 : 45;
            pick = $urandom_range(99);
            if (pick < reg_pct)
                op = OP_REGISTER;
            else if (pick < reg_pct + del_pct)
                op = OP_DELETE;
            else if (pick < 97)
                op = OP_W'($urandom_range(OP_KEY_OF_SLOT, OP_HAS));
            else
                op = OP_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
            key   = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(KEY_POOL - 1)];
            size  = ($urandom_range(4) == 0) ? SLOT_BITS'($urandom) : SLOT_BITS'($urandom_range(15));
            query = ($urandom_range(4) == 0) ? SLOT_BITS'($urandom) : SLOT_BITS'($urandom_range(15));
            send_request(op, key, size, query);
        end
        i_in_valid <= 1'b0;

        while (board.expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d register, %0d delete, %0d has, %0d slot-of-key, %0d key-of-slot",
                 board.op_count[OP_REGISTER], board.op_count[OP_DELETE], board.op_count[OP_HAS],
                 board.op_count[OP_SLOT_OF_KEY], board.op_count[OP_KEY_OF_SLOT]);
        $display("%0d table-full refusals, %0d fifo slot reuses, %0d replies checked, %0d errors",
                 board.full_count, board.reuse_count, board.checked, board.errors);
        if (board.errors == 0)
            $display("entity_slot_map_with_free_fifo verification clean");
        else
            $display("entity_slot_map_with_free_fifo verification failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d replies outstanding", board.expected_replies.size());
        $display("entity_slot_map_with_free_fifo verification failed");
        $finish;
    end

endmodule
